@@ src/hlsfr_pkg.sv @@
// shared constants, state codes and controller/datapath interface types
package hlsfr_pkg;

    localparam int unsigned MAX_PAYLOAD = 64;
    localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam logic [7:0] HDR_A = 8'hAA;
    localparam logic [7:0] HDR_B = 8'h55;

    typedef enum logic [2:0] {
        ST_HDR1,
        ST_HDR2,
        ST_LEN,
        ST_DATA,
        ST_SUM,
        ST_RD,
        ST_LD,
        ST_ONE
    } state_t;

    typedef struct packed {
        logic hdr_ok;
        logic len_load;
        logic data_wr;
        logic sum_chk;
        logic rd_issue;
        logic out_load_data;
        logic out_load_single;
    } cmd_t;

    typedef struct packed {
        logic hdr_a;
        logic hdr_b;
        logic len_in_zero;
        logic len_in_big;
        logic data_last;
        logic sum_ok;
        logic len_is_zero;
        logic rd_last;
        logic out_free;
    } stat_t;

endpackage

@@ src/hlsfr_ctrl.sv @@
// frame controller: hunt, header, length, payload, checksum and readout sequencing
module hlsfr_ctrl
    import hlsfr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  stat_t  st,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;
    logic   acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HDR1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_stall = !(state_reg inside {ST_HDR1, ST_HDR2, ST_LEN, ST_DATA, ST_SUM});
        acc      = in_valid && !in_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_HDR1:
            begin
                if (acc && st.hdr_a)
                begin
                    state_next = ST_HDR2;
                end
            end
            ST_HDR2:
            begin
                if (acc)
                begin
                    if (st.hdr_b)
                    begin
                        cmd.hdr_ok = 1'b1;
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        state_next = ST_HDR1;
                    end
                end
            end
            ST_LEN:
            begin
                if (acc)
                begin
                    if (st.len_in_big)
                    begin
                        state_next = ST_HDR1;
                    end
                    else
                    begin
                        cmd.len_load = 1'b1;
                        state_next   = st.len_in_zero ? ST_SUM : ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (acc)
                begin
                    cmd.data_wr = 1'b1;
                    if (st.data_last)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (acc)
                begin
                    cmd.sum_chk = 1'b1;
                    state_next  = (st.sum_ok && !st.len_is_zero) ? ST_RD : ST_ONE;
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LD;
            end
            ST_LD:
            begin
                if (st.out_free)
                begin
                    cmd.out_load_data = 1'b1;
                    state_next        = st.rd_last ? ST_HDR1 : ST_RD;
                end
            end
            ST_ONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load_single = 1'b1;
                    state_next          = ST_HDR1;
                end
            end
            default:
            begin
                state_next = ST_HDR1;
            end
        endcase
    end

    // a payload beat is only loaded after its memory read
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LD |-> $past(state_reg) == ST_RD || $past(state_reg) == ST_LD)
        else $error("readout load without preceding read");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_load_data && cmd.out_load_single))
        else $error("two output loads at once");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_chk |=> state_reg == ST_RD || state_reg == ST_ONE)
        else $error("checksum beat not followed by a report");

endmodule

@@ src/hlsfr_dpath.sv @@
// frame datapath: length, position, running sum, payload store and output register
module hlsfr_dpath
    import hlsfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output stat_t            st,
    input  logic [7:0]       rx_byte,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [7:0]       payload_byte,
    output logic             byte_valid,
    output logic             frame_status,
    output logic [LEN_W-1:0] frame_size,
    output logic             last_of_frame
);

    logic [7:0]       mem [MAX_PAYLOAD];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] wpos_reg;
    logic [LEN_W-1:0] rpos_reg;
    logic [7:0]       sum_reg;
    logic             err_reg;
    logic [7:0]       rdata_reg;
    logic             out_valid_reg;
    logic [7:0]       payload_reg;
    logic             bvalid_reg;
    logic             status_reg;
    logic [LEN_W-1:0] size_reg;
    logic             last_reg;
    logic [LEN_W-1:0] wpos_inc;
    logic [LEN_W-1:0] rpos_inc;

    assign wpos_inc = wpos_reg + LEN_W'(1);
    assign rpos_inc = rpos_reg + LEN_W'(1);

    always_comb
    begin
        st.hdr_a       = (rx_byte == HDR_A);
        st.hdr_b       = (rx_byte == HDR_B);
        st.len_in_zero = (rx_byte == 8'd0);
        st.len_in_big  = ({1'b0, rx_byte} > 9'(MAX_PAYLOAD));
        st.data_last   = (wpos_inc >= len_reg);
        st.sum_ok      = (sum_reg == rx_byte);
        st.len_is_zero = (len_reg == '0);
        st.rd_last     = (rpos_inc == len_reg);
        st.out_free    = !out_valid_reg || !out_stall;
    end

    // payload store
    always_ff @(posedge clk)
    begin
        if (cmd.data_wr)
        begin
            mem[wpos_reg[IDX_W-1:0]] <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            rdata_reg <= mem[rpos_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            wpos_reg <= '0;
            rpos_reg <= '0;
            sum_reg  <= '0;
            err_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.hdr_ok)
            begin
                sum_reg <= HDR_A + HDR_B;
            end
            if (cmd.len_load)
            begin
                len_reg  <= rx_byte[LEN_W-1:0];
                wpos_reg <= '0;
                sum_reg  <= sum_reg + rx_byte;
            end
            if (cmd.data_wr)
            begin
                wpos_reg <= wpos_inc;
                sum_reg  <= sum_reg + rx_byte;
            end
            if (cmd.sum_chk)
            begin
                err_reg  <= !st.sum_ok;
                rpos_reg <= '0;
            end
            if (cmd.out_load_data)
            begin
                rpos_reg <= rpos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load_data || cmd.out_load_single)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load_data)
        begin
            payload_reg <= rdata_reg;
            bvalid_reg  <= 1'b1;
            status_reg  <= 1'b0;
            size_reg    <= len_reg;
            last_reg    <= st.rd_last;
        end
        else if (cmd.out_load_single)
        begin
            payload_reg <= 8'd0;
            bvalid_reg  <= 1'b0;
            status_reg  <= err_reg;
            size_reg    <= len_reg;
            last_reg    <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = payload_reg;
    assign byte_valid    = bvalid_reg;
    assign frame_status  = status_reg;
    assign frame_size    = size_reg;
    assign last_of_frame = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.data_wr |-> wpos_reg < len_reg)
        else $error("payload write past frame length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load_data || cmd.out_load_single) |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while held");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && bvalid_reg |-> size_reg != '0 && !status_reg)
        else $error("payload beat with bad size or status");

endmodule

@@ src/header_length_sum_frame_receiver.sv @@
// top level of the length-prefixed frame receiver with additive checksum
//
//  channel   valid      stall      payload
//  -------   --------   --------   ----------------------------------------------
//  input     in_valid   in_stall   rx_byte
//  output    out_valid  out_stall  payload_byte, byte_valid, frame_status,
//                                  frame_size, last_of_frame
//
//  header, length, payload and checksum bytes are each accepted without stalling the input
//  readout of an accepted frame does a memory read, then an output register load, for each
//  payload beat, the load waiting while the output is held; an empty or error report is a single load
//  the input is stalled for the whole readout, set by the single payload store read port
//  rst_n clears the controller, counters and output valid; the store keeps stale bytes
//  a stalled output beat holds in the output register and halts the readout
module header_length_sum_frame_receiver
    import hlsfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       payload_byte,
    output logic             byte_valid,
    output logic             frame_status,
    output logic [LEN_W-1:0] frame_size,
    output logic             last_of_frame
);

    // commands from the controller, status back from the datapath
    cmd_t  cmd;
    stat_t st;

    hlsfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // holds the running sum, the payload store and the output beat register
    hlsfr_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .rx_byte       (rx_byte),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .payload_byte  (payload_byte),
        .byte_valid    (byte_valid),
        .frame_status  (frame_status),
        .frame_size    (frame_size),
        .last_of_frame (last_of_frame)
    );

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for the length-prefixed frame receiver with additive checksum
`timescale 1ns / 100ps

module tb_top;
    import hlsfr_pkg::*;

    localparam int unsigned SRC_ITEMS = 430;     // rough size of the byte stream
    localparam int unsigned DRAIN_CYC = 40;      // settle time once nothing is due
    localparam int unsigned LONG_HOLD = 300;     // one long receiver hold-off, in cycles
    localparam int unsigned LIMIT_NS  = 5000000; // hard ceiling on the whole run

    // one expected output beat
    typedef struct packed {
        logic [7:0]       data;
        logic             carried;
        logic             bad_sum;
        logic [LEN_W-1:0] size;
        logic             last;
    } frame_beat_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [7:0]       rx_byte = 8'h00;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       payload_byte;
    logic             byte_valid;
    logic             frame_status;
    logic [LEN_W-1:0] frame_size;
    logic             last_of_frame;

    // bytes still to be offered, and beats the receiver still owes us
    logic [7:0]  rx_pending[$];
    frame_beat_t frame_beats_due[$];

    int unsigned mismatch_count = 0;

    // own copy of the parser state
    state_t           fp_phase = ST_HDR1;
    logic [LEN_W-1:0] fp_len = '0;
    logic [LEN_W-1:0] fp_pos = '0;
    logic [7:0]       fp_sum = 8'h00;
    logic [7:0]       fp_store[MAX_PAYLOAD];

    // idle bookkeeping for both sides
    int unsigned src_wait = 0;
    int unsigned src_calm = 0;
    int unsigned sink_wait = 0;
    int unsigned sink_calm = 0;
    int unsigned sink_beats = 0;

    header_length_sum_frame_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_byte  (payload_byte),
        .byte_valid    (byte_valid),
        .frame_status  (frame_status),
        .frame_size    (frame_size),
        .last_of_frame (last_of_frame)
    );

    always #4 clk = ~clk;

    // idle count before the next beat: mostly drawn at random, now and then zero for a run of back-to-back beats
    function automatic int unsigned draw_idle(inout int unsigned calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic frame_beat_t make_beat(logic [7:0] data, logic carried, logic bad_sum,
                                              logic [LEN_W-1:0] size, logic last);
        frame_beat_t fb;
        fb.data    = data;
        fb.carried = carried;
        fb.bad_sum = bad_sum;
        fb.size    = size;
        fb.last    = last;
        return fb;
    endfunction

    task automatic restart_hunt();
        fp_phase = ST_HDR1;
        fp_len   = '0;
        fp_pos   = '0;
        fp_sum   = 8'h00;
    endtask

    // advance the parser by one accepted byte and queue whatever beats it releases
    task automatic frame_track(input logic [7:0] b);
        case (fp_phase)
            ST_HDR2:
            begin
                // anything but the second header byte, another first header included, drops back
                if (b == HDR_B)
                begin
                    fp_phase = ST_LEN;
                    fp_sum   = HDR_A + HDR_B;
                end
                else
                    fp_phase = ST_HDR1;
            end
            ST_LEN:
            begin
                // oversized length: back to the hunt without a report
                if (b > MAX_PAYLOAD)
                    restart_hunt();
                else
                begin
                    fp_len   = b[LEN_W-1:0];
                    fp_pos   = '0;
                    fp_sum   = fp_sum + b;
                    fp_phase = (b == 8'h00) ? ST_SUM : ST_DATA;
                end
            end
            ST_DATA:
            begin
                fp_store[fp_pos[IDX_W-1:0]] = b;
                fp_sum                      = fp_sum + b;
                fp_pos                      = fp_pos + 1'b1;
                if (fp_pos >= fp_len)
                    fp_phase = ST_SUM;
            end
            ST_SUM:
            begin
                if (fp_sum != b)
                    frame_beats_due.push_back(make_beat(8'h00, 1'b0, 1'b1, fp_len, 1'b1));
                else if (fp_len == 0)
                    frame_beats_due.push_back(make_beat(8'h00, 1'b0, 1'b0, '0, 1'b1));
                else
                    for (int i = 0; i < fp_len; i++)
                        frame_beats_due.push_back(make_beat(fp_store[IDX_W'(i)], 1'b1, 1'b0,
                                                            fp_len, (i + 1 == fp_len)));
                restart_hunt();
            end
            default:
                fp_phase = (b == HDR_A) ? ST_HDR2 : ST_HDR1;
        endcase
    endtask

    // append one complete frame, with a good or a corrupted checksum
    task automatic queue_frame(input int unsigned len, input bit good);
        logic [7:0] chk;
        logic [7:0] b;
        chk = HDR_A + HDR_B + len[7:0];
        rx_pending.push_back(HDR_A);
        rx_pending.push_back(HDR_B);
        rx_pending.push_back(len[7:0]);
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            chk = chk + b;
            rx_pending.push_back(b);
        end
        if (!good)
            chk = chk + 8'($urandom_range(1, 255));
        rx_pending.push_back(chk);
    endtask

    // sender: holds a stalled beat, otherwise idles for the drawn gap then offers the next byte
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
            src_wait = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                src_wait = draw_idle(src_calm);
            if (src_wait > 0)
            begin
                src_wait--;
                in_valid <= 1'b0;
            end
            else if (rx_pending.size() > 0)
            begin
                in_valid <= 1'b1;
                rx_byte  <= rx_pending.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stalls for the drawn count after each beat, now and then for a long spell; one long
    // hold-off early on lets the block back up and push back on its input
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                sink_beats++;
                if (sink_beats == 40)
                    sink_wait = LONG_HOLD;
                else if ($urandom_range(0, 199) == 0)
                    sink_wait = $urandom_range(60, 150);
                else
                    sink_wait = draw_idle(sink_calm);
            end
            else if (sink_wait > 0)
                sink_wait--;
            out_stall <= (sink_wait > 0);
        end
    end

    // monitor: check each delivered beat against the oldest one due, then track accepted input
    always @(posedge clk)
    begin
        frame_beat_t due;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (frame_beats_due.size() == 0)
                begin
                    $error("unexpected beat: payload_byte %0h last_of_frame %0b",
                           payload_byte, last_of_frame);
                    mismatch_count++;
                end
                else
                begin
                    due = frame_beats_due.pop_front();
                    if (payload_byte !== due.data)
                    begin
                        $error("payload_byte: expected %0h, got %0h", due.data, payload_byte);
                        mismatch_count++;
                    end
                    if (byte_valid !== due.carried)
                    begin
                        $error("byte_valid: expected %0b, got %0b", due.carried, byte_valid);
                        mismatch_count++;
                    end
                    if (frame_status !== due.bad_sum)
                    begin
                        $error("frame_status: expected %0b, got %0b", due.bad_sum, frame_status);
                        mismatch_count++;
                    end
                    if (frame_size !== due.size)
                    begin
                        $error("frame_size: expected %0d, got %0d", due.size, frame_size);
                        mismatch_count++;
                    end
                    if (last_of_frame !== due.last)
                    begin
                        $error("last_of_frame: expected %0b, got %0b", due.last, last_of_frame);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                frame_track(rx_byte);
        end
    end

    // stimulus and end of run
    initial
    begin
        int unsigned frame_no;
        int unsigned pick;
        int unsigned len;
        logic [7:0]  b;

        frame_no = 0;

        // empty frame, good and bad checksum
        rx_pending.push_back(HDR_A);
        rx_pending.push_back(HDR_B);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(HDR_A);
        rx_pending.push_back(HDR_B);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'h00);
        // repeated first header is not a fresh start, so the 0x55 after it is ignored
        rx_pending.push_back(HDR_A);
        rx_pending.push_back(HDR_A);
        rx_pending.push_back(HDR_B);
        // lengths just above the maximum and at the top of the byte range
        rx_pending.push_back(HDR_A);
        rx_pending.push_back(HDR_B);
        rx_pending.push_back(8'(MAX_PAYLOAD + 1));
        rx_pending.push_back(HDR_A);
        rx_pending.push_back(HDR_B);
        rx_pending.push_back(8'hFF);
        // one-byte frame carrying all ones, checksum wraps to 0xff
        rx_pending.push_back(HDR_A);
        rx_pending.push_back(HDR_B);
        rx_pending.push_back(8'h01);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(8'hFF);
        // one-byte frame with a corrupted checksum
        queue_frame(1, 1'b0);

        // random part: mostly well-formed frames, some noise, broken headers and oversized lengths
        while (rx_pending.size() < SRC_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                frame_no++;
                if (frame_no == 5 || frame_no == 25)
                    len = MAX_PAYLOAD;
                else if ($urandom_range(0, 11) == 0)
                    len = $urandom_range(9, MAX_PAYLOAD);
                else
                    len = $urandom_range(0, 8);
                queue_frame(len, $urandom_range(0, 4) != 0);
            end
            else if (pick == 7)
            begin
                repeat ($urandom_range(1, 4))
                    rx_pending.push_back(8'($urandom_range(0, 255)));
            end
            else if (pick == 8)
            begin
                // broken header
                do
                    b = 8'($urandom_range(0, 255));
                while (b == HDR_B);
                rx_pending.push_back(HDR_A);
                rx_pending.push_back(b);
            end
            else
            begin
                rx_pending.push_back(HDR_A);
                rx_pending.push_back(HDR_B);
                rx_pending.push_back(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // all bytes taken, every due beat delivered, then a quiet spell for strays
        wait (rx_pending.size() == 0 && !in_valid);
        wait (frame_beats_due.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
